FILE: hw/rtl/bom_pkg.sv
// shared constants and types for the buffer overlap marker
package bom_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_BITS   = 40;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

endpackage

FILE: hw/rtl/bom_overlap.sv
// half-open interval overlap test shared by every comparison step
module bom_overlap (
    input  bom_pkg::t_addr i_a,
    input  bom_pkg::t_addr i_sa,
    input  bom_pkg::t_addr i_b,
    input  bom_pkg::t_addr i_sb,
    output logic           o_hit
);
    import bom_pkg::*;

    logic [ADDR_BITS:0] end_a;
    logic [ADDR_BITS:0] end_b;

    // zero size never overlaps; otherwise each start lies below the other's end
    always_comb begin
        end_a = {1'b0, i_a} + {1'b0, i_sa};
        end_b = {1'b0, i_b} + {1'b0, i_sb};
        o_hit = (i_sa != '0) && (i_sb != '0)
             && ({1'b0, i_a} < end_b) && ({1'b0, i_b} < end_a);
    end

endmodule

FILE: hw/rtl/buffer_overlap_marker_top.sv
// top level of the buffer overlap marker: sequencer, entry memory and output register
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_start_of_set i_has_address i_address i_size
//  out       output     o_out_valid / i_out_stall    o_reused o_overflow
//
// an item with an address is checked against every stored buffer, an empty list included:
// one read of the entry memory and one pass through the overlap unit per stored buffer,
// then a drain of the read pipeline before the final state
// a skipped item skips the scan; a new item is taken while a result waits in the output register
// reset clears the entry count and the sequencer; the entry memory is not cleared,
// only entries below the count are ever read
// a stalled output holds the sequencer in its final state until the result register frees
module buffer_overlap_marker_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_start_of_set,
    input  logic           i_has_address,
    input  bom_pkg::t_addr i_address,
    input  bom_pkg::t_addr i_size,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_reused,
    output logic           o_overflow
);
    import bom_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // sequencer state
    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_issue, n_issue;
    logic   r_rd_vld, n_rd_vld;
    logic   r_hit, n_hit;
    logic   r_keep, n_keep;

    // current item
    t_addr  r_addr, r_size;

    // entry memory: address and size side by side
    logic [2*ADDR_BITS-1:0] mem [MAX_ENTRIES];
    logic [2*ADDR_BITS-1:0] r_rd_data;
    logic                   rd_en;
    logic                   wr_en;
    t_idx                   rd_idx;

    // output register
    logic   r_out_valid, n_out_valid;
    logic   r_reused, n_reused;
    logic   r_overflow, n_overflow;

    logic   in_xfer;
    logic   out_free;
    logic   cmp_hit;
    logic   full;

    bom_overlap u_overlap (
        .i_a   (r_addr),
        .i_sa  (r_size),
        .i_b   (r_rd_data[2*ADDR_BITS-1:ADDR_BITS]),
        .i_sb  (r_rd_data[ADDR_BITS-1:0]),
        .o_hit (cmp_hit)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign full        = (r_count == CNT_W'(MAX_ENTRIES));
    assign rd_idx      = r_issue[IDX_W-1:0];
    assign rd_en       = (r_state == S_SCAN) && (r_issue < r_count);
    assign wr_en       = (r_state == S_DONE) && out_free && r_keep && !full;

    assign o_out_valid = r_out_valid;
    assign o_reused    = r_reused;
    assign o_overflow  = r_overflow;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_rd_vld    = rd_en;
        n_hit       = r_hit;
        n_keep      = r_keep;
        n_out_valid = r_out_valid && i_out_stall;
        n_reused    = r_reused;
        n_overflow  = r_overflow;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // start of a new set drops all stored buffers
                    if (i_start_of_set) begin
                        n_count = '0;
                    end
                    n_issue = '0;
                    n_hit   = 1'b0;
                    n_keep  = i_has_address;
                    n_state = i_has_address ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && cmp_hit) begin
                    n_hit = 1'b1;
                end
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end else if (!r_rd_vld) begin
                    // last read compared, nothing in flight
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_reused    = r_hit;
                    n_overflow  = r_keep && full;
                    if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_keep      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_hit       <= n_hit;
            r_keep      <= n_keep;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_reused   <= n_reused;
        r_overflow <= n_overflow;
        if (in_xfer) begin
            r_addr <= i_address;
            r_size <= i_size;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IDX_W-1:0]] <= {r_addr, r_size};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_idx];
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the buffer overlap marker: directed, pressure and random sets
`timescale 1ns / 1ps

module testbench;
    import bom_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1150;

    // one expected output transfer
    typedef struct packed {
        logic reused;
        logic overflow;
    } t_mark;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    logic  start_of_set = 1'b0;
    logic  has_address = 1'b0;
    t_addr buf_address = '0;
    t_addr buf_size = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    logic  reused;
    logic  overflow;

    // buffers the predictor has kept in the current set
    t_addr kept_address [MAX_ENTRIES];
    t_addr kept_size [MAX_ENTRIES];
    int    kept_count = 0;

    t_mark expected_marks [$];

    int  failures = 0;
    int  sent_items = 0;
    int  cycle_count = 0;
    bit  idling = 1'b1;    // random gaps on both sides when set
    int  hold_cycles = 0;  // long receiver hold-off, counted down by the receiver
    int  stall_left = 0;   // short stall drawn after each output transfer

    buffer_overlap_marker_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_of_set (start_of_set),
        .i_has_address  (has_address),
        .i_address      (buf_address),
        .i_size         (buf_size),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_reused       (reused),
        .o_overflow     (overflow)
    );

    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // predicts the marking of one buffer and updates the kept list
    // the end addresses are formed 64 bits wide so the sums never wrap
    function automatic t_mark mark_buffer(bit first, bit valid, t_addr addr, t_addr len);
        t_mark       mark;
        logic [63:0] lo, hi, end_new, end_kept;
        mark = '0;
        if (first)
            kept_count = 0;
        if (valid) begin
            for (int k = 0; k < kept_count; k++) begin
                end_new  = 64'(addr) + 64'(len);
                end_kept = 64'(kept_address[k]) + 64'(kept_size[k]);
                lo = (addr < kept_address[k]) ? 64'(addr) : 64'(kept_address[k]);
                hi = (end_new > end_kept) ? end_new : end_kept;
                // half-open spans overlap when the joint extent is shorter than the sum of both sizes
                if (hi - lo < 64'(len) + 64'(kept_size[k]))
                    mark.reused = 1'b1;
            end
            if (kept_count < MAX_ENTRIES) begin
                kept_address[kept_count] = addr;
                kept_size[kept_count]    = len;
                kept_count++;
            end else begin
                mark.overflow = 1'b1;
            end
        end
        return mark;
    endfunction

    function automatic t_addr rand_wide();
        return t_addr'({$urandom(), $urandom()});
    endfunction

    // offers one buffer and returns right after the rising edge that takes it
    // payload and valid only change at the falling edge
    task automatic send_buffer(bit first, bit valid, t_addr addr, t_addr len);
        int gap;
        gap = idling ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start_of_set <= first;
        has_address  <= valid;
        buf_address  <= addr;
        buf_size     <= len;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        expected_marks.insert(expected_marks.size(), mark_buffer(first, valid, addr, len));
        sent_items++;
    endtask

    // sender pause until every expected transfer has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_marks.size() != 0) @(posedge clk);
    endtask

    // receiver: long hold-off first, then the short per-transfer stall
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // output checker: every transfer against the oldest expectation
    always @(posedge clk) begin
        t_mark want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_marks.size() == 0) begin
                $error("result transfer with nothing expected: reused %0b overflow %0b",
                       reused, overflow);
                failures++;
            end else begin
                want = expected_marks.pop_front();
                if (reused !== want.reused) begin
                    $error("reused: expected %0b, actual %0b", want.reused, reused);
                    failures++;
                end
                if (overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
                    failures++;
                end
            end
            stall_left = idling ? $urandom_range(0, 4) : 0;
        end
    end

    // empty list straight out of reset, then a zero-size buffer against it
    task automatic test_after_reset();
        send_buffer(1'b0, 1'b1, 40'd0, 40'd0);
        send_buffer(1'b0, 1'b1, 40'd0, 40'd1);
        send_buffer(1'b0, 1'b1, 40'd0, 40'd1);
    endtask

    // skipped buffers are neither compared nor kept, but a start on one still clears
    task automatic test_skipped();
        send_buffer(1'b1, 1'b1, 40'h10_0000, 40'h100);
        send_buffer(1'b0, 1'b0, 40'h10_0000, 40'h100);
        send_buffer(1'b1, 1'b0, 40'h10_0000, 40'h100);
        send_buffer(1'b0, 1'b1, 40'h10_0000, 40'h100);
        send_buffer(1'b0, 1'b0, '1, '1);
    endtask

    // boundaries of half-open spans: touching is not overlapping
    task automatic test_span_edges();
        send_buffer(1'b1, 1'b1, 40'd1000, 40'd100);
        send_buffer(1'b0, 1'b1, 40'd1100, 40'd100);
        send_buffer(1'b0, 1'b1, 40'd900, 40'd100);
        send_buffer(1'b1, 1'b1, 40'd1000, 40'd100);
        send_buffer(1'b0, 1'b1, 40'd1099, 40'd1);
        send_buffer(1'b0, 1'b1, 40'd1050, 40'd0);
        send_buffer(1'b0, 1'b1, 40'd899, 40'd102);
    endtask

    // field extremes and alternating bit patterns
    task automatic test_extremes();
        send_buffer(1'b1, 1'b1, '1, '1);
        send_buffer(1'b0, 1'b1, '0, '1);
        send_buffer(1'b0, 1'b1, '1, 40'd1);
        send_buffer(1'b1, 1'b1, 40'h55_5555_5555, 40'hAA_AAAA_AAAA);
        send_buffer(1'b0, 1'b1, 40'hAA_AAAA_AAAA, 40'h55_5555_5555);
        send_buffer(1'b0, 1'b1, 40'hFF_FFFF_FFFE, 40'd0);
    endtask

    // fill the list, then overflow with a hit and misses; a skipped buffer in between does not overflow
    task automatic test_full_store();
        for (int n = 0; n < MAX_ENTRIES; n++)
            send_buffer(n == 0, 1'b1, t_addr'(n * 64), 40'd32);
        send_buffer(1'b0, 1'b1, 40'd16, 40'd8);
        send_buffer(1'b0, 1'b1, 40'h80_0000_0000, 40'd8);
        send_buffer(1'b0, 1'b0, 40'd16, 40'd8);
        send_buffer(1'b0, 1'b1, 40'd40, 40'd10);
        send_buffer(1'b1, 1'b1, 40'd16, 40'd8);
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_output_hold();
        t_addr base;
        wait_drained();
        hold_cycles = 300;
        base = rand_wide();
        for (int n = 0; n < 16; n++)
            send_buffer(n == 0, 1'b1, base + t_addr'($urandom_range(0, 255)),
                        t_addr'($urandom_range(0, 64)));
        wait_drained();
    endtask

    // a stretch with no gaps on either side
    task automatic test_back_to_back();
        idling = 1'b0;
        for (int n = 0; n < 40; n++)
            send_buffer(n % 10 == 0, $urandom_range(0, 7) != 0,
                        t_addr'($urandom_range(0, 1023)), t_addr'($urandom_range(0, 48)));
        wait_drained();
        idling = 1'b1;
    endtask

    // random sets: mostly short clustered sets, some wide-random, a few past the list size
    task automatic test_random_sets();
        int    set_len;
        int    style;
        bit    first;
        bit    valid;
        t_addr base;
        t_addr addr;
        t_addr len;
        while (sent_items < ITEM_TARGET) begin
            set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 12);
            style = $urandom_range(0, 3);
            base  = (style == 2) ? t_addr'('1) - t_addr'($urandom_range(0, 4095)) : rand_wide();
            for (int n = 0; n < set_len; n++) begin
                case (style)
                    0, 2: begin
                        addr = base + t_addr'($urandom_range(0, 511));
                        len  = t_addr'($urandom_range(0, 96));
                    end
                    1: begin
                        addr = rand_wide();
                        len  = rand_wide();
                    end
                    default: begin
                        addr = rand_wide();
                        len  = rand_wide() >> $urandom_range(0, 39);
                    end
                endcase
                first = (n == 0) || ($urandom_range(0, 39) == 0);
                valid = $urandom_range(0, 9) != 0;
                send_buffer(first, valid, addr, len);
            end
            // now and then let everything come out before the next set
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_skipped();
        test_span_edges();
        test_extremes();
        test_full_store();
        test_output_hold();
        test_back_to_back();
        test_random_sets();

        wait_drained();
        // let a late or extra transfer show up before judging
        repeat (MAX_ENTRIES + 16) @(posedge clk);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
